[design/mahrs_pkg.sv]
// ----------------------------------------------------------------------------
// Homing ramp sequencer package
// Widths, phase encoding, configuration indexes and reset values shared by
// the channel interfaces and the sequencer.
// ----------------------------------------------------------------------------
package mahrs_pkg;

    localparam int AXES      = 6;
    localparam int AXIS_W    = 3;
    localparam int NUM_SLOTS = 1 << AXIS_W;
    localparam int POS_W     = 32;
    localparam int SETTLE_W  = 16;
    localparam int PERIOD_W  = 24;
    localparam int STEP_W    = 31;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 24;

    localparam logic [AXIS_W:0] AXES_LIMIT = (AXIS_W + 1)'(AXES);

    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 1'd1;

    localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd16777;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] PHC_INIT   = 2'd0;
    localparam logic [1:0] PHC_TORQUE = 2'd1;
    localparam logic [1:0] PHC_MOVE   = 2'd2;
    localparam logic [1:0] PHC_DONE   = 2'd3;

    typedef enum logic [3:0] {
        PH_INIT   = 4'b0001,
        PH_TORQUE = 4'b0010,
        PH_MOVE   = 4'b0100,
        PH_DONE   = 4'b1000
    } t_phase;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_INIT:   code = PHC_INIT;
            PH_TORQUE: code = PHC_TORQUE;
            PH_MOVE:   code = PHC_MOVE;
            PH_DONE:   code = PHC_DONE;
            default:   code = PHC_INIT;
        endcase
        return code;
    endfunction

endpackage

[design/mahrs_item_if.sv]
// ----------------------------------------------------------------------------
// Homing sequencer input channel
// Valid/ready channel carrying one start or axis sample beat.
// ----------------------------------------------------------------------------
interface mahrs_item_if
    import mahrs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [AXIS_W-1:0]        axis;
    logic                     last_axis;
    logic signed [POS_W-1:0]  now_position;
    logic signed [POS_W-1:0]  home_position;
    logic signed [POS_W-1:0]  homing_speed;

    modport source (
        output valid, op, axis, last_axis, now_position, home_position, homing_speed,
        input  ready
    );
    modport sink (
        input  valid, op, axis, last_axis, now_position, home_position, homing_speed,
        output ready
    );
endinterface

[design/mahrs_result_if.sv]
// ----------------------------------------------------------------------------
// Homing sequencer result channel
// Valid/ready channel carrying one drive command beat per input beat.
// ----------------------------------------------------------------------------
interface mahrs_result_if
    import mahrs_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [AXIS_W-1:0]        out_axis;
    logic signed [POS_W-1:0]  target_position;
    logic                     target_write;
    logic                     torque_enable;
    logic                     drive_defaults;
    logic [1:0]               phase;
    logic                     all_done;

    modport source (
        output valid, out_axis, target_position, target_write, torque_enable,
               drive_defaults, phase, all_done,
        input  ready
    );
    modport sink (
        input  valid, out_axis, target_position, target_write, torque_enable,
               drive_defaults, phase, all_done,
        output ready
    );
endinterface

[design/multi_axis_homing_ramp_sequencer.sv]
// A beat is registered in the input stage, which holds the step multiply, and then
// in the result register; the per-axis target update sits in the result stage.
// One beat per cycle unless the result channel stalls; no beat waits on another.
// Reset (synchronous, active low) returns to the initial phase, clears the settle
// counter, directions and done flag, and restores the register defaults.
// Axis targets are not reset; they are written in the initial phase.
// ----------------------------------------------------------------------------
// Multi-axis homing ramp sequencer
// Walks each joint target toward home in fixed steps after a torque-on settle
// period and reports a drive command per axis sample.
// ----------------------------------------------------------------------------
module multi_axis_homing_ramp_sequencer
    import mahrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    mahrs_item_if.sink           i_item,
    mahrs_result_if.source       o_result
);

    // Configuration.
    logic [SETTLE_W-1:0] r_settle_ticks;
    logic [PERIOD_W-1:0] r_tick_period;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_settle_ticks <= SETTLE_RESET;
            r_tick_period  <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SETTLE_TICKS: r_settle_ticks <= i_cfg_data[SETTLE_W-1:0];
                CFG_TICK_PERIOD:  r_tick_period  <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic advance;
    logic s1_load;
    logic s2_load;

    assign advance        = !r_out_valid || o_result.ready;
    assign i_item.ready   = !r_s1_valid || advance;
    assign s1_load        = i_item.valid && i_item.ready;
    assign s2_load        = r_s1_valid && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // Input stage: register the beat and form the step size.
    logic [POS_W-1:0]            speed_mag;
    logic [POS_W+PERIOD_W-1:0]   step_prod;

    assign speed_mag = i_item.homing_speed[POS_W-1]
                     ? (POS_W)'(-i_item.homing_speed) : i_item.homing_speed;
    assign step_prod = (POS_W + PERIOD_W)'(speed_mag) * (POS_W + PERIOD_W)'(r_tick_period);

    logic                    r_s1_op;
    logic [AXIS_W-1:0]       r_s1_axis;
    logic                    r_s1_last;
    logic signed [POS_W-1:0] r_s1_now;
    logic signed [POS_W-1:0] r_s1_home;
    logic [STEP_W-1:0]       r_s1_step;
    logic                    r_s1_moving;

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_op     <= i_item.op;
            r_s1_axis   <= i_item.axis;
            r_s1_last   <= i_item.last_axis;
            r_s1_now    <= i_item.now_position;
            r_s1_home   <= i_item.home_position;
            r_s1_step   <= step_prod[PERIOD_W +: STEP_W];
            r_s1_moving <= (speed_mag != '0);
        end
    end

    // Sequencer state.
    t_phase                  r_phase, n_phase;
    logic [SETTLE_W-1:0]     r_settle, n_settle;
    logic                    r_reached, n_reached;
    logic                    r_done, n_done;
    logic [NUM_SLOTS-1:0]    r_dir;
    logic signed [POS_W-1:0] r_target [NUM_SLOTS];

    logic                    axis_ok;
    logic signed [POS_W-1:0] cur;
    logic                    up;
    logic signed [POS_W:0]   sum;
    logic signed [POS_W-1:0] sat;
    logic                    clamp;

    logic                    tgt_we;
    logic signed [POS_W-1:0] tgt;
    logic                    dir_we;
    logic                    dir_clr;
    logic                    wr, tq, dd;

    assign axis_ok = ({1'b0, r_s1_axis} < AXES_LIMIT);
    assign cur     = r_target[r_s1_axis];
    assign up      = r_dir[r_s1_axis];
    assign sum     = up ? ({cur[POS_W-1], cur} + $signed({2'b00, r_s1_step}))
                        : ({cur[POS_W-1], cur} - $signed({2'b00, r_s1_step}));

    // Saturate the 33-bit sum back to the signed 32-bit range.
    always_comb begin
        if (sum[POS_W] != sum[POS_W-1]) begin
            sat = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            sat = sum[POS_W-1:0];
        end
    end

    assign clamp = r_s1_moving && (up ? (sat > r_s1_home) : (sat < r_s1_home));

    always_comb begin
        n_phase   = r_phase;
        n_settle  = r_settle;
        n_reached = r_reached;
        n_done    = r_done;
        tgt_we    = 1'b0;
        tgt       = '0;
        dir_we    = 1'b0;
        dir_clr   = 1'b0;
        wr        = 1'b0;
        tq        = 1'b0;
        dd        = 1'b0;
        if (r_s1_op == OP_START) begin
            n_phase   = PH_INIT;
            n_settle  = '0;
            dir_clr   = 1'b1;
            n_reached = 1'b1;
            n_done    = 1'b0;
        end else begin
            unique case (r_phase)
                PH_INIT: begin
                    if (axis_ok) begin
                        tgt_we = 1'b1;
                        tgt    = r_s1_now;
                        dir_we = 1'b1;
                        wr     = 1'b1;
                    end
                    if (r_s1_last) begin
                        n_phase = PH_TORQUE;
                    end
                end
                PH_TORQUE: begin
                    tq = axis_ok && (r_settle == '0);
                    if (r_s1_last) begin
                        priority if (r_settle == '0) begin
                            n_settle = SETTLE_W'(1);
                        end else if (r_settle == r_settle_ticks) begin
                            n_phase  = PH_MOVE;
                            n_settle = '0;
                        end else begin
                            n_settle = r_settle + SETTLE_W'(1);
                        end
                    end
                end
                PH_MOVE: begin
                    if (axis_ok) begin
                        tgt_we = 1'b1;
                        tgt    = clamp ? r_s1_home : sat;
                        wr     = 1'b1;
                        dd     = 1'b1;
                        if (!clamp) begin
                            n_reached = 1'b0;
                        end
                    end
                    // A tick in which every axis clamped ends the move.
                    if (r_s1_last) begin
                        if (n_reached) begin
                            n_phase = PH_DONE;
                        end
                        n_reached = 1'b1;
                    end
                end
                PH_DONE: begin
                    n_done = 1'b1;
                end
                default: begin
                    n_phase = PH_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_INIT;
            r_settle  <= '0;
            r_reached <= 1'b1;
            r_done    <= 1'b0;
            r_dir     <= '0;
        end else if (s2_load) begin
            r_phase   <= n_phase;
            r_settle  <= n_settle;
            r_reached <= n_reached;
            r_done    <= n_done;
            if (dir_clr) begin
                r_dir <= '0;
            end else if (dir_we) begin
                r_dir[r_s1_axis] <= (r_s1_home >= r_s1_now);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load && tgt_we) begin
            r_target[r_s1_axis] <= tgt;
        end
    end

    // Result register.
    logic [AXIS_W-1:0]       r_out_axis;
    logic signed [POS_W-1:0] r_out_target;
    logic                    r_out_wr;
    logic                    r_out_tq;
    logic                    r_out_dd;
    logic [1:0]              r_out_phase;
    logic                    r_out_done;

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_out_axis   <= r_s1_axis;
            r_out_target <= tgt;
            r_out_wr     <= wr;
            r_out_tq     <= tq;
            r_out_dd     <= dd;
            r_out_phase  <= phase_code(n_phase);
            r_out_done   <= n_done;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.out_axis        = r_out_axis;
    assign o_result.target_position = r_out_target;
    assign o_result.target_write    = r_out_wr;
    assign o_result.torque_enable   = r_out_tq;
    assign o_result.drive_defaults  = r_out_dd;
    assign o_result.phase           = r_out_phase;
    assign o_result.all_done        = r_out_done;

`ifndef NO_ASSERTIONS
    a_torque_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_tq |-> r_out_phase == PHC_TORQUE)
        else $error("torque request outside the torque-on phase");

    a_defaults_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_dd |-> r_out_wr && r_out_phase != PHC_INIT)
        else $error("drive defaults without a target write");

    a_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_done |-> r_out_phase == PHC_DONE)
        else $error("done flag outside the completed phase");

    a_settle_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_settle != '0 |-> r_phase == PH_TORQUE)
        else $error("settle counter running outside the torque-on phase");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s2_load |=> $stable(r_phase) && $stable(r_settle) && $stable(r_done))
        else $error("sequencer state changed without a beat");
`endif

endmodule
